FILE: hw/rtl/talu_pkg.sv
// ----------------------------------------------------------------------------
// talu_pkg: shared types for the tagged ALU
// Operation codes and relocation tag codes.
// ----------------------------------------------------------------------------
package talu_pkg;

   typedef enum logic [3:0] {
      CMD_ADD      = 4'd0,
      CMD_SUB      = 4'd1,
      CMD_MUL      = 4'd2,
      CMD_DIV      = 4'd3,
      CMD_MOD      = 4'd4,
      CMD_AND      = 4'd5,
      CMD_OR       = 4'd6,
      CMD_XOR      = 4'd7,
      CMD_ANDNOT   = 4'd8,
      CMD_NOT      = 4'd9,
      CMD_NEG      = 4'd10,
      CMD_SIGNFLIP = 4'd11
   } cmd_type;

   typedef enum logic [1:0] {
      TAG_UNKNOWN = 2'd0,
      TAG_ABS     = 2'd1,
      TAG_REL     = 2'd2
   } tag_type;

endpackage

FILE: hw/rtl/talu_div_step.sv
// ----------------------------------------------------------------------------
// talu_div_step: one restoring division step
// Shifts the remainder/quotient pair left by one and retires one quotient bit.
// ----------------------------------------------------------------------------
module talu_div_step #(
   parameter int VALUE_WIDTH = 36
) (
   input  logic [2*VALUE_WIDTH-1:0] rq,
   input  logic [VALUE_WIDTH-1:0]   divisor,
   output logic [2*VALUE_WIDTH-1:0] rq_next
);

   logic [VALUE_WIDTH:0] top;
   logic [VALUE_WIDTH:0] diff;
   logic                 ge;

   always_comb begin
      top  = rq[2*VALUE_WIDTH-1:VALUE_WIDTH-1];
      diff = top - {1'b0, divisor};
      ge   = (top >= {1'b0, divisor});
      rq_next = {(ge ? diff[VALUE_WIDTH-1:0] : top[VALUE_WIDTH-1:0]),
                 rq[VALUE_WIDTH-2:0], ge};
   end

endmodule

FILE: hw/rtl/tagged_alu_36bit.sv
// ----------------------------------------------------------------------------
// tagged_alu_36bit: pipelined ALU over relocation-tagged operands
// Add, subtract, multiply, unsigned divide and modulus, bitwise and unary
// operations with relocation tag tracking and error flags.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one operation per transaction (command plus two tagged
//   operands); rsp_* returns one result transaction for each request, in order.
//   csr_wr_en/csr_wr_data set final_pass, which enables the type and section
//   error flags; write it only while no transaction is in flight.
//   Throughput is one transaction per cycle while the skid register is empty.
//   The pipeline depth is set by the restoring divider, which retires one
//   quotient bit per pipeline stage; multiply runs in parallel over the first
//   two divider stages as partial products.
//   Reset clears all pipeline valid bits, the output and skid valid flags and
//   final_pass.
//   When the receiver stalls, the response holds and one more result lands in
//   a skid register; while the skid register is full the pipeline holds and
//   req_tready is low.
// ----------------------------------------------------------------------------
module tagged_alu_36bit #(
   parameter int VALUE_WIDTH   = 36,
   parameter int SECTION_COUNT = 16,
   localparam int SW    = $clog2(SECTION_COUNT),
   localparam int REQ_W = ((2*VALUE_WIDTH + 2*SW + 8 + 7) / 8) * 8,
   localparam int RSP_W = ((VALUE_WIDTH + SW + 5 + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data,
   input  logic             req_tvalid,
   output logic             req_tready,
   // cmd, first_value, first_type, first_section,
   // second_value, second_type, second_section
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // result_value, result_type, result_section,
   // type_error, divide_by_zero, section_mismatch
   output logic [RSP_W-1:0] rsp_tdata
);

   import talu_pkg::*;

   localparam int W    = VALUE_WIDTH;
   localparam int LO   = W / 2;
   localparam int BO   = W + 6 + SW;
   localparam int RSPB = W + SW + 5;

   logic             final_pass_ff;
   logic             en;

   logic             s0_valid_in;
   cmd_type          s0_cmd_in;
   logic [W-1:0]     s0_val_in;
   tag_type          s0_type_in;
   logic [SW-1:0]    s0_sec_in;
   logic             s0_te_in;
   logic             s0_dz_in;
   logic             s0_sm_in;

   logic [W-1:0]     in_a;
   logic [W-1:0]     in_b;
   logic [1:0]       in_at;
   logic [1:0]       in_bt;
   logic [SW-1:0]    in_as;
   logic [SW-1:0]    in_bs;

   logic             valid_ff [0:W];
   cmd_type          cmd_ff   [0:W];
   logic [W-1:0]     val_ff   [0:W];
   tag_type          type_ff  [0:W];
   logic [SW-1:0]    sec_ff   [0:W];
   logic             te_ff    [0:W];
   logic             dz_ff    [0:W];
   logic             sm_ff    [0:W];
   logic [2*W-1:0]   rq_ff    [0:W];
   logic [W-1:0]     dvs_ff   [0:W];
   logic [2*W-1:0]   rq_in    [1:W];

   logic [2*LO-1:0]  p_ll_ff;
   logic [W-1:0]     p_hl_ff;
   logic [W-1:0]     p_lh_ff;
   logic [W-1:0]     prod_in;

   logic [W-1:0]     fin_val;
   logic [RSP_W-1:0] fin_data;

   logic             out_valid_ff;
   logic [RSP_W-1:0] out_data_ff;
   logic             skid_valid_ff;
   logic [RSP_W-1:0] skid_data_ff;

   assign en         = !skid_valid_ff;
   assign req_tready = en;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         final_pass_ff <= 1'b0;
      end else if (csr_wr_en) begin
         final_pass_ff <= csr_wr_data;
      end
   end

   // decode and combinational operations
   always_comb begin
      logic a_abs;
      logic b_abs;
      logic a_rel;
      logic b_rel;
      logic bad;
      logic sm;
      in_a  = req_tdata[W+3:4];
      in_at = req_tdata[W+5:W+4];
      in_as = req_tdata[W+5+SW:W+6];
      in_b  = req_tdata[BO+W-1:BO];
      in_bt = req_tdata[BO+W+1:BO+W];
      in_bs = req_tdata[BO+W+1+SW:BO+W+2];
      s0_valid_in = req_tvalid;
      s0_cmd_in   = cmd_type'(req_tdata[3:0]);
      a_abs = (in_at == TAG_ABS);
      b_abs = (in_bt == TAG_ABS);
      a_rel = (in_at == TAG_REL);
      b_rel = (in_bt == TAG_REL);
      bad = 1'b0;
      sm  = 1'b0;
      s0_type_in = TAG_UNKNOWN;
      s0_sec_in  = in_as;
      s0_dz_in   = 1'b0;
      s0_val_in  = in_a;
      case (s0_cmd_in)
         CMD_ADD:      s0_val_in = in_a + in_b;
         CMD_SUB:      s0_val_in = in_a - in_b;
         CMD_DIV, CMD_MOD: s0_dz_in = (in_b == '0);
         CMD_AND:      s0_val_in = in_a & in_b;
         CMD_OR:       s0_val_in = in_a | in_b;
         CMD_XOR:      s0_val_in = in_a ^ in_b;
         CMD_ANDNOT:   s0_val_in = in_a & ~in_b;
         CMD_NOT:      s0_val_in = ~in_a;
         CMD_NEG:      s0_val_in = '0 - in_a;
         CMD_SIGNFLIP: s0_val_in = in_a ^ {1'b1, {(W-1){1'b0}}};
         default:      s0_val_in = in_a;
      endcase
      unique case (s0_cmd_in)
         CMD_ADD: begin
            if (a_abs && b_abs) s0_type_in = TAG_ABS;
            else if (a_rel && b_abs) s0_type_in = TAG_REL;
            else if (a_abs && b_rel) begin
               s0_type_in = TAG_REL;
               s0_sec_in  = in_bs;
            end else bad = 1'b1;
         end
         CMD_SUB: begin
            if (a_abs && b_abs) s0_type_in = TAG_ABS;
            else if (a_rel && b_abs) s0_type_in = TAG_REL;
            else if (a_rel && b_rel) begin
               s0_type_in = TAG_ABS;
               s0_sec_in  = in_bs;
               sm = (in_as != in_bs);
            end else bad = 1'b1;
         end
         CMD_MUL, CMD_DIV, CMD_MOD, CMD_AND, CMD_OR, CMD_XOR, CMD_ANDNOT: begin
            if (a_abs && b_abs) s0_type_in = TAG_ABS;
            else bad = 1'b1;
         end
         CMD_NOT, CMD_NEG, CMD_SIGNFLIP: begin
            if (a_abs) s0_type_in = TAG_ABS;
            else bad = 1'b1;
         end
         default: bad = 1'b1;
      endcase
      if (bad) begin
         s0_type_in = TAG_UNKNOWN;
         s0_sec_in  = in_as;
      end
      s0_te_in = bad && final_pass_ff;
      s0_sm_in = sm && final_pass_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= s0_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cmd_ff[0]  <= s0_cmd_in;
         val_ff[0]  <= s0_val_in;
         type_ff[0] <= s0_type_in;
         sec_ff[0]  <= s0_sec_in;
         te_ff[0]   <= s0_te_in;
         dz_ff[0]   <= s0_dz_in;
         sm_ff[0]   <= s0_sm_in;
         rq_ff[0]   <= {{W{1'b0}}, in_a};
         dvs_ff[0]  <= in_b;
      end
   end

   // partial products, summed combinationally into val_ff[2]
   always_ff @(posedge clock) begin
      if (en) begin
         p_ll_ff <= rq_ff[0][LO-1:0] * dvs_ff[0][LO-1:0];
         p_hl_ff <= rq_ff[0][W-1:LO] * dvs_ff[0][LO-1:0];
         p_lh_ff <= rq_ff[0][LO-1:0] * dvs_ff[0][W-1:LO];
      end
   end

   always_comb begin
      logic [W-1:0] cross_sum;
      cross_sum = p_hl_ff + p_lh_ff;
      prod_in   = W'(p_ll_ff) + (cross_sum << LO);
   end

   for (genvar k = 1; k <= W; k++) begin : g_stage
      talu_div_step #(.VALUE_WIDTH(W)) u_step (
         .rq      (rq_ff[k-1]),
         .divisor (dvs_ff[k-1]),
         .rq_next (rq_in[k])
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            cmd_ff[k]  <= cmd_ff[k-1];
            type_ff[k] <= type_ff[k-1];
            sec_ff[k]  <= sec_ff[k-1];
            te_ff[k]   <= te_ff[k-1];
            dz_ff[k]   <= dz_ff[k-1];
            sm_ff[k]   <= sm_ff[k-1];
            rq_ff[k]   <= rq_in[k];
            dvs_ff[k]  <= dvs_ff[k-1];
            if (k == 2 && cmd_ff[k-1] == CMD_MUL) begin
               val_ff[k] <= prod_in;
            end else begin
               val_ff[k] <= val_ff[k-1];
            end
         end
      end
   end

   always_comb begin
      fin_val = val_ff[W];
      if (cmd_ff[W] == CMD_DIV && !dz_ff[W]) begin
         fin_val = rq_ff[W][W-1:0];
      end else if (cmd_ff[W] == CMD_MOD && !dz_ff[W]) begin
         fin_val = rq_ff[W][2*W-1:W];
      end
      fin_data = RSP_W'({sm_ff[W], dz_ff[W], te_ff[W], sec_ff[W], type_ff[W], fin_val});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= valid_ff[W];
         end
      end else if (en && valid_ff[W]) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_tready) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : fin_data;
      end else if (en && valid_ff[W]) begin
         skid_data_ff <= fin_data;
      end
   end

endmodule

FILE: hw/rtl/talu_checker.sv
// ----------------------------------------------------------------------------
// talu_checker: response channel checks for the tagged ALU
// Watches the top-level response ports over time.
// ----------------------------------------------------------------------------
module talu_checker #(
   parameter int VALUE_WIDTH   = 36,
   parameter int SECTION_COUNT = 16,
   localparam int SW    = $clog2(SECTION_COUNT),
   localparam int RSP_W = ((VALUE_WIDTH + SW + 5 + 7) / 8) * 8
) (
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   import talu_pkg::*;

   localparam int TP = VALUE_WIDTH;
   localparam int TE = VALUE_WIDTH + 2 + SW;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   a_te_unknown: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[TE] |-> rsp_tdata[TP+1:TP] == TAG_UNKNOWN)
      else $error("type error with known tag");

   a_sm_abs: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[TE+2] |-> rsp_tdata[TP+1:TP] == TAG_ABS
         && !rsp_tdata[TE] && !rsp_tdata[TE+1])
      else $error("section mismatch on non-absolute result");

endmodule

bind tagged_alu_36bit talu_checker #(
   .VALUE_WIDTH   (VALUE_WIDTH),
   .SECTION_COUNT (SECTION_COUNT)
) u_talu_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
